// File: rtl/rfsd_pkg.sv
// Shared types and widths for the rotation frame split detector.
package rfsd_pkg;

    localparam int unsigned ANGLE_W = 16;

    typedef logic [ANGLE_W-1:0] angle_t;

    // Held azimuth count, saturating at two
    typedef logic [1:0] hist_count_t;

    localparam hist_count_t HIST_FULL = 2'd2;

    typedef struct packed {
        logic split;
        logic reverse;
    } decision_t;

endpackage

// File: rtl/rfsd_decide.sv
// Step, direction and frame start crossing decision for one azimuth.
module rfsd_decide
(
    input  rfsd_pkg::angle_t    prev_angle,
    input  rfsd_pkg::angle_t    old_angle,
    input  rfsd_pkg::angle_t    cur_angle,
    input  rfsd_pkg::angle_t    start_angle,
    input  logic                history_full,
    input  logic                reverse_in,
    output rfsd_pkg::decision_t decision
);

    rfsd_pkg::angle_t d1;
    rfsd_pkg::angle_t d2;
    rfsd_pkg::angle_t step;
    logic             old_gt_prev;
    logic             prev_gt_cur;
    logic             cur_gt_prev;
    logic             rev;
    logic             split;

    always_comb
    begin
        old_gt_prev = old_angle > prev_angle;
        prev_gt_cur = prev_angle > cur_angle;
        cur_gt_prev = cur_angle > prev_angle;
        d1 = old_gt_prev ? (old_angle - prev_angle) : (prev_angle - old_angle);
        d2 = prev_gt_cur ? (prev_angle - cur_angle) : (cur_angle - prev_angle);
        step = (d1 > d2) ? d2 : d1;

        // A decreasing neighbour pair that sets the step means reverse rotation
        rev = (old_gt_prev && (d1 == step)) || (prev_gt_cur && (d2 == step));

        if (!rev)
        begin
            if (prev_gt_cur && (d2 > step))
                split = (start_angle > prev_angle) || (start_angle <= cur_angle);
            else
                split = cur_gt_prev && (prev_angle < start_angle)
                        && (cur_angle >= start_angle);
        end
        else
        begin
            if (cur_gt_prev && (d2 > step))
                split = (start_angle < prev_angle) || (start_angle >= cur_angle);
            else
                split = prev_gt_cur && (prev_angle > start_angle)
                        && (cur_angle <= start_angle);
        end

        // Too little history or a zero step: hold the direction, no split
        if (!history_full || (step == '0))
        begin
            decision.split   = 1'b0;
            decision.reverse = reverse_in;
        end
        else
        begin
            decision.split   = split;
            decision.reverse = rev;
        end
    end

endmodule

// File: rtl/rotation_frame_split_detector.sv
// Top level of the rotation frame split detector: registers, handshakes and history.
// A request is accepted into the input register; its decision is then registered in
// the result register, which raises out_valid and holds until it is taken.
// Throughput: one request per cycle; the input register and the result register
// advance together whenever the result register is empty or being taken.
// Reset (rst_n low, asynchronous): history cleared, forward rotation, frame start
// angle zero, both pipeline registers empty.
module rotation_frame_split_detector
(
    input  logic                    clk,
    input  logic                    rst_n,

    input  logic                    in_valid,
    output logic                    in_stall,
    input  rfsd_pkg::angle_t        azimuth,

    output logic                    out_valid,
    input  logic                    out_stall,
    output logic                    split_frame,
    output logic                    reverse_rotation,

    input  logic                    cfg_valid,
    output logic                    cfg_ready,
    input  rfsd_pkg::angle_t        frame_start_angle
);

    logic                  in_valid_reg;
    rfsd_pkg::angle_t      in_angle_reg;
    logic                  out_valid_reg;
    rfsd_pkg::decision_t   out_reg;
    rfsd_pkg::angle_t      start_reg;
    rfsd_pkg::angle_t      prev_reg;
    rfsd_pkg::angle_t      old_reg;
    rfsd_pkg::hist_count_t count_reg;
    rfsd_pkg::hist_count_t count_next;
    logic                  reverse_reg;
    rfsd_pkg::decision_t   decision;
    logic                  advance;
    logic                  in_take;

    assign advance   = in_valid_reg && (!out_valid_reg || !out_stall);
    assign in_stall  = in_valid_reg && !advance;
    assign in_take   = in_valid && !in_stall;
    assign cfg_ready = 1'b1;

    assign out_valid        = out_valid_reg;
    assign split_frame      = out_reg.split;
    assign reverse_rotation = out_reg.reverse;

    assign count_next = (count_reg == rfsd_pkg::HIST_FULL)
                        ? count_reg : count_reg + 2'd1;

    rfsd_decide u_decide
    (
        .prev_angle   (prev_reg),
        .old_angle    (old_reg),
        .cur_angle    (in_angle_reg),
        .start_angle  (start_reg),
        .history_full (count_reg == rfsd_pkg::HIST_FULL),
        .reverse_in   (reverse_reg),
        .decision     (decision)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            start_reg     <= '0;
            prev_reg      <= '0;
            old_reg       <= '0;
            count_reg     <= '0;
            reverse_reg   <= 1'b0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
                start_reg <= frame_start_angle;

            if (in_take)
                in_valid_reg <= 1'b1;
            else if (advance)
                in_valid_reg <= 1'b0;

            if (advance)
                out_valid_reg <= 1'b1;
            else if (!out_stall)
                out_valid_reg <= 1'b0;

            // Shift the history and commit the direction as the request moves on
            if (advance)
            begin
                old_reg     <= prev_reg;
                prev_reg    <= in_angle_reg;
                count_reg   <= count_next;
                reverse_reg <= decision.reverse;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
            in_angle_reg <= azimuth;
        if (advance)
            out_reg <= decision;
    end

endmodule
